### design/dorb_pkg.sv
// ----------------------------------------------------------------------------
// dorb_pkg: shared types and constants for the dual overwrite ring buffer
// Transfer structs, command and ring codes, default geometry.
// ----------------------------------------------------------------------------
package dorb_pkg;

  // Fixed field widths of the transfer structs
  localparam int REC_DATA_W = 64;
  localparam int DROP_W     = 32;

  // Default geometry
  localparam int CRITICAL_DEPTH_DEF = 1024;
  localparam int STANDARD_DEPTH_DEF = 4096;
  localparam int RECORD_WIDTH_DEF   = 64;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Ring select codes
  localparam logic RING_CRITICAL = 1'b0;
  localparam logic RING_STANDARD = 1'b1;

  // Input transfer
  typedef struct packed {
    logic                  command;
    logic                  ring_select;
    logic [REC_DATA_W-1:0] record_data;
  } dorb_item_t;

  // Result transfer
  typedef struct packed {
    logic                  read_valid;
    logic [REC_DATA_W-1:0] read_data;
    logic                  overwrote_oldest;
    logic                  now_empty;
    logic [DROP_W-1:0]     drop_count;
  } dorb_result_t;

  // Per-ring status for the current access
  typedef struct packed {
    logic dropped;
    logic popped;
    logic now_empty;
  } ring_stat_t;

endpackage

### design/dorb_ring.sv
// ----------------------------------------------------------------------------
// dorb_ring: one overwrite-oldest record FIFO
// Record memory with registered read, head pointer and fill count.
// ----------------------------------------------------------------------------
module dorb_ring #(
  parameter int DEPTH        = dorb_pkg::CRITICAL_DEPTH_DEF,
  parameter int RECORD_WIDTH = dorb_pkg::RECORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     op_en,
  input  logic                     op_read,
  input  logic [RECORD_WIDTH-1:0]  wdata,
  output dorb_pkg::ring_stat_t     stat,
  output logic [RECORD_WIDTH-1:0]  rdata
);
  import dorb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [RECORD_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0] head, head_next, head_inc, tail, waddr;
  logic [FW-1:0] fill, fill_next;
  logic [AW:0]   sum;
  logic          full, empty, pop, push, drop;

  // Occupancy and pointer arithmetic
  assign full     = (fill == FW'(DEPTH));
  assign empty    = (fill == '0);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign sum      = (AW+1)'(head) + (AW+1)'(fill);
  assign tail     = (sum >= (AW+1)'(DEPTH)) ? AW'(sum - (AW+1)'(DEPTH)) : AW'(sum);
  // a full ring overwrites the oldest slot, which is the old head
  assign waddr    = full ? head : tail;

  assign pop  = op_en &  op_read & ~empty;
  assign push = op_en & ~op_read;
  assign drop = push & full;

  // Next pointer state
  always_comb begin
    head_next = head;
    fill_next = fill;
    if (pop) begin
      head_next = head_inc;
      fill_next = fill - FW'(1);
    end else if (drop) begin
      head_next = head_inc;
    end else if (push) begin
      fill_next = fill + FW'(1);
    end
  end

  assign stat.dropped   = drop;
  assign stat.popped    = pop;
  assign stat.now_empty = (fill_next == '0);

  // Pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  // Record memory: one access per transfer, read data registered
  always_ff @(posedge clk) begin
    if (push) begin
      mem[waddr] <= wdata;
    end
    if (pop) begin
      rdata <= mem[head];
    end
  end

endmodule

### design/dual_overwrite_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// dual_overwrite_ring_buffer_unit: critical and standard overwrite-oldest FIFOs
// Write or read one ring per transfer; shared saturating drop counter.
// ----------------------------------------------------------------------------
// A result strobes on done in the cycle after its transfer is accepted.
// Throughput: one transfer per cycle; busy stays low, since each access is a
//   single read or write on one port of the selected ring's memory.
// Reset: pointers, fill counts and the drop counter clear; record
//   memories are not cleared, as entries are only read after being written.
// The receiver cannot stall: every result is valid for exactly one cycle.
module dual_overwrite_ring_buffer_unit #(
  parameter int CRITICAL_DEPTH = dorb_pkg::CRITICAL_DEPTH_DEF,
  parameter int STANDARD_DEPTH = dorb_pkg::STANDARD_DEPTH_DEF,
  parameter int RECORD_WIDTH   = dorb_pkg::RECORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  dorb_pkg::dorb_item_t   item,
  output logic                   done,
  output dorb_pkg::dorb_result_t result
);
  import dorb_pkg::*;

  logic                    accept, crit_en, std_en;
  logic [RECORD_WIDTH-1:0] wdata, crit_rdata, std_rdata, sel_rdata;
  ring_stat_t              crit_stat, std_stat, sel_stat;
  logic [DROP_W-1:0]       drop_cnt;
  logic                    hit, over, empty_flag, sel;

  // Every cycle can take a transfer
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign crit_en = accept & (item.ring_select == RING_CRITICAL);
  assign std_en  = accept & (item.ring_select == RING_STANDARD);
  assign wdata   = item.record_data[RECORD_WIDTH-1:0];

  dorb_ring #(
    .DEPTH        (CRITICAL_DEPTH),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_crit (
    .clk     (clk),
    .rst     (rst),
    .op_en   (crit_en),
    .op_read (item.command == CMD_READ),
    .wdata   (wdata),
    .stat    (crit_stat),
    .rdata   (crit_rdata)
  );

  dorb_ring #(
    .DEPTH        (STANDARD_DEPTH),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_std (
    .clk     (clk),
    .rst     (rst),
    .op_en   (std_en),
    .op_read (item.command == CMD_READ),
    .wdata   (wdata),
    .stat    (std_stat),
    .rdata   (std_rdata)
  );

  assign sel_stat = (item.ring_select == RING_STANDARD) ? std_stat : crit_stat;

  // Saturating drop counter, shared by both rings
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_cnt <= '0;
    end else if (accept && sel_stat.dropped && (drop_cnt != '1)) begin
      drop_cnt <= drop_cnt + DROP_W'(1);
    end
  end

  // Result stage, lines up with the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      hit        <= 1'b0;
      over       <= 1'b0;
      empty_flag <= 1'b0;
      sel        <= RING_CRITICAL;
    end else begin
      done       <= accept;
      hit        <= accept & sel_stat.popped;
      over       <= accept & sel_stat.dropped;
      empty_flag <= sel_stat.now_empty;
      sel        <= item.ring_select;
    end
  end

  assign sel_rdata = (sel == RING_STANDARD) ? std_rdata : crit_rdata;

  assign result.read_valid       = hit;
  assign result.read_data        = hit ? REC_DATA_W'(sel_rdata) : '0;
  assign result.overwrote_oldest = over;
  assign result.now_empty        = empty_flag;
  assign result.drop_count       = drop_cnt;

  // A result never both pops and drops
  a_pop_xor_drop: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.read_valid && result.overwrote_oldest))
    else $error("result reports both a pop and a drop");

  // A drop always leaves a nonzero counter
  a_drop_counted: assert property (@(posedge clk) disable iff (rst)
    (done && result.overwrote_oldest) |-> (result.drop_count != '0))
    else $error("drop reported with zero drop count");

  // Pop and drop flags only show up with a strobe
  a_flags_need_done: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!result.read_valid && !result.overwrote_oldest))
    else $error("result flags set without a strobe");

  // Each strobe follows an accepted transfer
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start))
    else $error("strobe without a preceding transfer");

endmodule
